@@ rtl/lru_key_value_cache_unit_defines.svh @@
// Assertion macros for the LRU key/value cache unit checker.
// Used by lkvc_checker.sv; expects a clock named clk and a reset named rst in scope.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// Check on every clock edge outside of reset
`define LKVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included
`define LKVC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lkvc_pkg.sv @@
// Shared types and constants for the LRU key/value cache unit.
// No dependencies; imported by the top level and the checker.
package lkvc_pkg;

  // Fixed widths of the transaction fields
  localparam int KEY_BITS  = 32;
  localparam int DATA_BITS = 32;

  // Default sizing of the store
  localparam int CAPACITY_DEF    = 8;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [DATA_BITS-1:0] read_value;
  } rsp_t;

endpackage

@@ rtl/lru_key_value_cache_unit.sv @@
// Fully associative key/value cache with least-recently-used replacement.
// Depends on lkvc_pkg for the request/response types and default sizes.

// Takes one get or put transaction per cycle when the response side is not
// stalled and returns exactly one response for each. The request is
// registered, all CAPACITY entries are compared against its key in parallel,
// and the response register and the entry state update on the same edge, so
// the next request already sees the new contents. A get hit returns the
// stored value; a miss or any put returns zero, with hit set when the key
// was present. Only the low KEY_WIDTH and VALUE_WIDTH bits are stored.
module lru_key_value_cache_unit
  import lkvc_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PR_W   = RANK_W + 1;
  localparam logic [PR_W-1:0]   CAP_RANK    = PR_W'(CAPACITY);
  localparam logic [RANK_W-1:0] OLDEST_RANK = RANK_W'(CAPACITY - 1);

  // Request stage
  logic s1_valid;
  req_t s1;

  // Entry state
  logic [CAPACITY-1:0]    entry_valid;
  logic [RANK_W-1:0]      rank        [CAPACITY];
  logic [KEY_WIDTH-1:0]   key_store   [CAPACITY];
  logic [VALUE_WIDTH-1:0] value_store [CAPACITY];

  // Lookup results
  logic                   advance;
  logic                   fire;
  logic                   is_put;
  logic                   hit;
  logic                   full;
  logic                   do_update;
  logic [KEY_WIDTH-1:0]   key_in;
  logic [VALUE_WIDTH-1:0] val_in;
  logic [CAPACITY-1:0]    match;
  logic [CAPACITY-1:0]    victim;
  logic [CAPACITY-1:0]    free_lowest;
  logic [CAPACITY-1:0]    tgt;
  logic [RANK_W-1:0]      hit_rank;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [PR_W-1:0]        promo_rank;

  // Handshake: the request stage drains whenever the response slot frees up
  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || advance;
  assign fire      = s1_valid && advance;

  assign key_in = KEY_WIDTH'(s1.key);
  assign val_in = VALUE_WIDTH'(s1.value);
  assign is_put = (s1.cmd == CMD_PUT);

  // Compare all entries in parallel; keys are unique, so matches OR together
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]  = entry_valid[i] && (key_store[i] == key_in);
      victim[i] = entry_valid[i] && (rank[i] == OLDEST_RANK);
      hit_rank  = hit_rank | (rank[i] & {RANK_W{match[i]}});
      hit_value = hit_value | (value_store[i] & {VALUE_WIDTH{match[i]}});
    end
  end

  assign hit         = |match;
  assign full        = &entry_valid;
  // Isolate the lowest invalid entry
  assign free_lowest = ~entry_valid & (entry_valid + CAPACITY'(1));
  assign tgt         = hit ? match : (full ? victim : free_lowest);
  assign do_update   = fire && (hit || is_put);
  // Entries more recent than this one age by one; a new entry ages all others
  assign promo_rank  = hit ? {1'b0, hit_rank} : CAP_RANK;

  // Update valid bits and recency ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank[i] <= '0;
      end
    end else if (do_update) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (tgt[i]) begin
          entry_valid[i] <= 1'b1;
          rank[i]        <= '0;
        end else if (entry_valid[i] && ({1'b0, rank[i]} < promo_rank)) begin
          rank[i] <= rank[i] + RANK_W'(1);
        end
      end
    end
  end

  // Write key and value on a put
  always_ff @(posedge clk) begin
    if (fire && is_put) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (tgt[i]) begin
          key_store[i]   <= key_in;
          value_store[i] <= val_in;
        end
      end
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1 <= req;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.hit        <= hit;
      rsp.read_value <= (hit && !is_put) ? DATA_BITS'(hit_value) : '0;
    end
  end

endmodule

@@ rtl/lkvc_checker.sv @@
// Port-level checker for the LRU key/value cache unit, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_unit_defines.svh.
`include "lru_key_value_cache_unit_defines.svh"

module lkvc_checker
  import lkvc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // No response may be pending right after reset
  `LKVC_ASSERT_ALWAYS(a_rst_clears_rsp, rst |=> !rsp_valid, "response valid after reset")

  // A nonzero value only comes back from a hit
  `LKVC_ASSERT(a_value_needs_hit, rsp_valid |-> (rsp.hit || rsp.read_value == '0), "value without hit")

  // A stalled response holds
  `LKVC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response changed while stalled")

  // With the response slot empty the unit always takes a new transaction
  `LKVC_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "request stalled with empty response slot")

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);
